FILE: hw/rtl/tip_pkg.sv
// Shared types and constants for the tagged interval profiler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tip_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned TS_W      = 48;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SUM_W     = 64;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } tip_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FEW       = 2'd3
  } tip_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_CALC,
    S_UPDATE,
    S_CLEAR,
    S_DONE
  } tip_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [TS_W-1:0]  lo;
    logic [TS_W-1:0]  hi;
  } tip_stats_t;

  localparam tip_stats_t STATS_INIT = '{
    cnt: CNT_W'(0),
    sum: SUM_W'(0),
    lo:  {TS_W{1'b1}},
    hi:  TS_W'(0)
  };

  typedef struct packed {
    logic        take;
    logic        scan;
    logic        commit;
    logic        calc;
    logic        update;
    logic        sweep;
    logic        set_st;
    tip_status_e st;
    logic        load_out;
  } tip_cmd_t;

  typedef struct packed {
    tip_op_e op;
    logic    hit;
    logic    free;
    logic    idx_last;
    logic    few;
    logic    out_free;
  } tip_sts_t;

endpackage

FILE: hw/rtl/tip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on tip_pkg for default sizes.
`timescale 1ns / 1ps

module tip_ram
  import tip_pkg::*;
#(
  parameter int unsigned WIDTH = TAG_W,
  parameter int unsigned DEPTH = SLOTS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tip_ctrl.sv
// Sequencing FSM of the tagged interval profiler.
// Depends on tip_pkg; drives tip_datapath through tip_cmd_t.
`timescale 1ns / 1ps

module tip_ctrl
  import tip_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  tip_sts_t        sts_i,
  output tip_cmd_t        cmd_o
);

  tip_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (tip_op_e'(in_op_i) == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_DONE;
        unique case (sts_i.op)
          OP_BEGIN: begin
            cmd_o.commit = 1'b1;
            if (!sts_i.hit && !sts_i.free) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_FULL;
            end
          end
          OP_END, OP_READ: begin
            if (!sts_i.hit) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_NOT_FOUND;
            end else begin
              state_d = S_CALC;
            end
          end
          OP_CLEAR: begin
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (sts_i.op == OP_READ) begin
          state_d = S_DONE;
          if (sts_i.few) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_FEW;
          end
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tip_datapath.sv
// Datapath: slot scan, slot memories, statistics arithmetic, output register.
// Depends on tip_pkg and tip_ram; commanded by tip_ctrl.
`timescale 1ns / 1ps

module tip_datapath
  import tip_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tip_cmd_t          cmd_i,
  output tip_sts_t          sts_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [ST_W-1:0]   status_o,
  output logic [CNT_W-1:0]  calls_o,
  output logic [SUM_W-1:0]  trimmed_total_o,
  output logic [TS_W-1:0]   shortest_o,
  output logic [TS_W-1:0]   longest_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  tip_op_e          op_q;
  logic [TAG_W-1:0] tag_q;
  logic [TS_W-1:0]  ts_q;
  logic [IW-1:0]    idx_q, cmp_idx_q, slot_q, free_idx_q;
  logic             cmp_v_q, hit_q, free_q;
  logic [SLOTS-1:0] used_q;
  tip_stats_t       st_q;
  logic [TS_W-1:0]  el_q;
  logic [SUM_W-1:0] trim_q;
  tip_status_e      res_q;
  logic             out_valid_q;
  tip_status_e      out_status_q;
  logic [CNT_W-1:0] out_calls_q;
  logic [SUM_W-1:0] out_trim_q;
  logic [TS_W-1:0]  out_lo_q, out_hi_q;

  logic [TAG_W-1:0] key_rd;
  logic [TS_W-1:0]  start_rd;
  tip_stats_t       stat_rd;
  logic             match, empty, alloc, start_we, stat_we, good;
  logic [IW-1:0]    start_waddr, stat_waddr;
  tip_stats_t       upd, stat_wdata;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] hi_ext, trim2, trim1;

  assign match = cmp_v_q && used_q[cmp_idx_q] && (key_rd == tag_q);
  assign empty = cmp_v_q && !used_q[cmp_idx_q];
  assign alloc = cmd_i.commit && !hit_q && free_q;

  assign start_we    = cmd_i.commit && (hit_q || free_q);
  assign start_waddr = hit_q ? slot_q : free_idx_q;

  assign stat_we    = cmd_i.update || cmd_i.sweep || alloc;
  assign stat_waddr = cmd_i.update ? slot_q : (cmd_i.sweep ? idx_q : free_idx_q);
  assign stat_wdata = cmd_i.update ? upd : STATS_INIT;

  always_comb begin
    sum_ext = {1'b0, st_q.sum} + (SUM_W + 1)'(el_q);
    upd.cnt = (st_q.cnt == {CNT_W{1'b1}}) ? st_q.cnt : st_q.cnt + CNT_W'(1);
    upd.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    upd.lo  = (el_q < st_q.lo) ? el_q : st_q.lo;
    upd.hi  = (el_q > st_q.hi) ? el_q : st_q.hi;
  end

  assign trim1  = (stat_rd.sum >= SUM_W'(stat_rd.lo)) ? stat_rd.sum - SUM_W'(stat_rd.lo)
                                                       : SUM_W'(0);
  assign hi_ext = SUM_W'(st_q.hi);
  assign trim2  = (trim_q >= hi_ext) ? trim_q - hi_ext : SUM_W'(0);
  assign good   = (op_q == OP_READ) && (res_q == ST_OK);

  tip_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (alloc),
    .waddr_i (free_idx_q),
    .wdata_i (tag_q),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  tip_ram #(.WIDTH(TS_W), .DEPTH(SLOTS)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (start_we),
    .waddr_i (start_waddr),
    .wdata_i (ts_q),
    .raddr_i (slot_q),
    .rdata_o (start_rd)
  );

  tip_ram #(.WIDTH($bits(tip_stats_t)), .DEPTH(SLOTS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (stat_wdata),
    .raddr_i (slot_q),
    .rdata_o (stat_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        idx_q   <= '0;
        cmp_v_q <= 1'b0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        cmp_v_q <= cmd_i.scan;
        if ((cmd_i.scan || cmd_i.sweep) && (idx_q != LAST)) begin
          idx_q <= idx_q + IW'(1);
        end
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (empty && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (alloc) begin
        used_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= tip_op_e'(op_i);
      tag_q <= tag_i;
      ts_q  <= timestamp_i;
      res_q <= ST_OK;
    end else if (cmd_i.set_st) begin
      res_q <= cmd_i.st;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= idx_q;
    end
    if (match && !hit_q) begin
      slot_q <= cmp_idx_q;
    end
    if (empty && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.calc) begin
      st_q   <= stat_rd;
      el_q   <= ts_q - start_rd;
      trim_q <= trim1;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_q;
      out_calls_q  <= good ? st_q.cnt - CNT_W'(2) : CNT_W'(0);
      out_trim_q   <= good ? trim2 : SUM_W'(0);
      out_lo_q     <= good ? st_q.lo : TS_W'(0);
      out_hi_q     <= good ? st_q.hi : TS_W'(0);
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.hit      = hit_q;
  assign sts_o.free     = free_q;
  assign sts_o.idx_last = (idx_q == LAST);
  assign sts_o.few      = (stat_rd.cnt < CNT_W'(2));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign calls_o         = out_calls_q;
  assign trimmed_total_o = out_trim_q;
  assign shortest_o      = out_lo_q;
  assign longest_o       = out_hi_q;

endmodule

FILE: hw/rtl/tagged_interval_profiler_unit.sv
// Top level of the tagged interval profiler: controller plus datapath.
// Depends on tip_pkg, tip_ctrl, tip_datapath (and tip_ram below it).
//
// Profiles up to SLOTS tagged code sections. Each transfer carries an op (begin, end,
// clear statistics, read) with a 32-bit tag and a 48-bit timestamp and yields exactly
// one result transfer. Tags are looked up by scanning the key memory one slot per
// cycle; a clear instead runs a sweep over the statistics memory. Items are handled
// one at a time. A new item is taken while the previous result still waits in the
// output register.
// Slot occupancy is held in flip-flops cleared by reset, so no clearing pass runs.
`timescale 1ns / 1ps

module tagged_interval_profiler_unit
  import tip_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [TS_W-1:0]   timestamp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ST_W-1:0]   status_o,
  output logic [CNT_W-1:0]  calls_o,
  output logic [SUM_W-1:0]  trimmed_total_o,
  output logic [TS_W-1:0]   shortest_o,
  output logic [TS_W-1:0]   longest_o
);

  tip_cmd_t cmd;
  tip_sts_t sts;

  tip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tip_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .tag_i           (tag_i),
    .timestamp_i     (timestamp_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .calls_o         (calls_o),
    .trimmed_total_o (trimmed_total_o),
    .shortest_o      (shortest_o),
    .longest_o       (longest_o)
  );

endmodule

FILE: hw/rtl/tip_checker.sv
// Port-level assertions for the tagged interval profiler, bound to the top level.
// Depends on tip_pkg and tagged_interval_profiler_unit.
`timescale 1ns / 1ps

module tip_checker
  import tip_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [OP_W-1:0]   op_i,
  input logic [TAG_W-1:0]  tag_i,
  input logic [TS_W-1:0]   timestamp_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ST_W-1:0]   status_o,
  input logic [CNT_W-1:0]  calls_o,
  input logic [SUM_W-1:0]  trimmed_total_o,
  input logic [TS_W-1:0]   shortest_o,
  input logic [TS_W-1:0]   longest_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      in_valid_i && $stable(op_i) && $stable(tag_i) && $stable(timestamp_i))
    else $error("waiting input transfer changed");

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 2'd0))
    else $error("result shown with no item outstanding");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      (calls_o == '0) && (trimmed_total_o == '0) && (shortest_o == '0) &&
      (longest_o == '0))
    else $error("error result carries nonzero statistics");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      out_valid_o && $stable(status_o) && $stable(calls_o) &&
      $stable(trimmed_total_o) && $stable(shortest_o) && $stable(longest_o))
    else $error("stalled result changed");

endmodule

bind tagged_interval_profiler_unit tip_checker u_tip_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .op_i            (op_i),
  .tag_i           (tag_i),
  .timestamp_i     (timestamp_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .calls_o         (calls_o),
  .trimmed_total_o (trimmed_total_o),
  .shortest_o      (shortest_o),
  .longest_o       (longest_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for tagged_interval_profiler_unit: a directed table, then random
// begin/end/read/clear traffic; results checked against typed steps or the in-bench model.
// Depends on tip_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import tip_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int TARGET_EVENTS  = 1100;
  localparam int POOL           = 20;
  localparam int DRAIN_CYCLES   = SLOTS + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    tip_status_e      st;
    logic [CNT_W-1:0] calls;
    logic [SUM_W-1:0] trimmed;
    logic [TS_W-1:0]  shortest;
    logic [TS_W-1:0]  longest;
  } result_t;

  typedef struct packed {
    tip_op_e          op;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  ts;
    logic             typed;
    result_t          res;
  } step_t;

  localparam result_t R_OK   = '{ST_OK, '0, '0, '0, '0};
  localparam result_t R_FULL = '{ST_FULL, '0, '0, '0, '0};
  localparam result_t R_MISS = '{ST_NOT_FOUND, '0, '0, '0, '0};
  localparam result_t R_FEW  = '{ST_FEW, '0, '0, '0, '0};
  localparam int      N_PLAN = 22;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i;
  logic [TAG_W-1:0]  tag_i;
  logic [TS_W-1:0]   timestamp_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ST_W-1:0]   status_o;
  logic [CNT_W-1:0]  calls_o;
  logic [SUM_W-1:0]  trimmed_total_o;
  logic [TS_W-1:0]   shortest_o;
  logic [TS_W-1:0]   longest_o;

  // slot table model
  logic [TAG_W-1:0] tag_key   [SLOTS];
  bit   [SLOTS-1:0] slot_busy;
  logic [TS_W-1:0]  mark_ts   [SLOTS];
  logic [CNT_W-1:0] hit_count [SLOTS];
  logic [SUM_W-1:0] span_sum  [SLOTS];
  logic [TS_W-1:0]  span_min  [SLOTS];
  logic [TS_W-1:0]  span_max  [SLOTS];

  result_t pending_stats [$];
  int      error_count;
  int      events_sent;
  int      results_seen;
  int      good_reads;
  int      status_seen [4];
  int      stuck_cycles;
  bit      src_quiet;
  bit      sink_quiet;

  step_t plan [N_PLAN] = '{
    '{OP_READ,  32'hFFFF_FFFF, 48'h0,               1'b1, R_MISS},
    '{OP_END,   32'h0,         48'h0,               1'b1, R_MISS},
    '{OP_BEGIN, 32'h0,         48'h0,               1'b1, R_OK},
    '{OP_READ,  32'h0,         48'h0,               1'b1, R_FEW},
    '{OP_END,   32'h0,         48'hFFFF_FFFF_FFFF,  1'b1, R_OK},
    '{OP_BEGIN, 32'h0,         48'hFFFF_FFFF_FFFF,  1'b1, R_OK},
    '{OP_END,   32'h0,         48'h5,               1'b1, R_OK},
    '{OP_READ,  32'h0,         48'h0,               1'b0, R_OK},
    '{OP_BEGIN, 32'h0,         48'd100,             1'b1, R_OK},
    '{OP_END,   32'h0,         48'd130,             1'b1, R_OK},
    '{OP_READ,  32'h0,         48'h0,               1'b0, R_OK},
    '{OP_BEGIN, 32'hFFFF_FFFF, 48'h8000_0000_0000,  1'b1, R_OK},
    '{OP_BEGIN, 32'hFFFF_FFFF, 48'h8000_0000_0010,  1'b1, R_OK},
    '{OP_END,   32'hFFFF_FFFF, 48'h8000_0000_0020,  1'b1, R_OK},
    '{OP_READ,  32'hFFFF_FFFF, 48'h0,               1'b1, R_FEW},
    '{OP_END,   32'hFFFF_FFFF, 48'h8000_0000_0040,  1'b1, R_OK},
    '{OP_READ,  32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF,  1'b0, R_OK},
    '{OP_CLEAR, 32'hA5A5_5A5A, 48'h5A5A_A5A5_5A5A,  1'b1, R_OK},
    '{OP_READ,  32'h0,         48'h0,               1'b1, R_FEW},
    '{OP_READ,  32'hFFFF_FFFF, 48'h0,               1'b1, R_FEW},
    '{OP_END,   32'h0,         48'd200,             1'b1, R_OK},
    '{OP_READ,  32'h1234_5678, 48'h0,               1'b1, R_MISS}
  };

  tagged_interval_profiler_unit #(.SLOTS(SLOTS)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .tag_i          (tag_i),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .calls_o        (calls_o),
    .trimmed_total_o(trimmed_total_o),
    .shortest_o     (shortest_o),
    .longest_o      (longest_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void wipe_stats(int i);
    hit_count[i] = '0;
    span_sum[i]  = '0;
    span_min[i]  = '1;
    span_max[i]  = '0;
  endfunction

  function automatic result_t account_event(tip_op_e op, logic [TAG_W-1:0] tag,
                                            logic [TS_W-1:0] ts);
    result_t          r;
    int               hit;
    int               i;
    logic [TS_W-1:0]  span;
    logic [SUM_W-1:0] rest;
    r   = R_OK;
    hit = -1;
    for (i = SLOTS - 1; i >= 0; i--)
      if (slot_busy[i] && tag_key[i] == tag) hit = i;
    case (op)
      OP_BEGIN: begin
        if (hit < 0) begin
          for (i = SLOTS - 1; i >= 0; i--)
            if (!slot_busy[i]) hit = i;
          if (hit >= 0) begin
            slot_busy[hit] = 1'b1;
            tag_key[hit]   = tag;
            wipe_stats(hit);
          end
        end
        if (hit < 0) r.st = ST_FULL;
        else mark_ts[hit] = ts;
      end
      OP_END: begin
        if (hit < 0) begin
          r.st = ST_NOT_FOUND;
        end else begin
          span = ts - mark_ts[hit];
          if (hit_count[hit] != '1) hit_count[hit]++;
          if (span_sum[hit] > ~SUM_W'(span)) span_sum[hit] = '1;
          else span_sum[hit] += SUM_W'(span);
          if (span < span_min[hit]) span_min[hit] = span;
          if (span > span_max[hit]) span_max[hit] = span;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < SLOTS; i++)
          if (slot_busy[i]) wipe_stats(i);
      end
      OP_READ: begin
        if (hit < 0) begin
          r.st = ST_NOT_FOUND;
        end else if (hit_count[hit] < 2) begin
          r.st = ST_FEW;
        end else begin
          rest = span_sum[hit];
          rest = (rest >= SUM_W'(span_min[hit])) ? rest - SUM_W'(span_min[hit]) : '0;
          rest = (rest >= SUM_W'(span_max[hit])) ? rest - SUM_W'(span_max[hit]) : '0;
          r.calls    = hit_count[hit] - 2;
          r.trimmed  = rest;
          r.shortest = span_min[hit];
          r.longest  = span_max[hit];
          good_reads++;
        end
      end
    endcase
    return r;
  endfunction

  function automatic step_t ev(tip_op_e op, logic [TAG_W-1:0] tag, logic [TS_W-1:0] ts);
    step_t s;
    s = '{op, tag, ts, 1'b0, R_OK};
    return s;
  endfunction

  function automatic logic [TS_W-1:0] wide_rand();
    return TS_W'({$urandom(), $urandom()});
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // entered and left at a falling edge
  task automatic send_event(input step_t s);
    int      gap;
    result_t want;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= s.op;
    tag_i       <= s.tag;
    timestamp_i <= s.ts;
    do @(posedge clk_i); while (!in_ready_o);
    want = account_event(s.op, s.tag, s.ts);
    if (s.typed) want = s.res;
    pending_stats.push_back(want);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    status_seen[status_o]++;
    if (pending_stats.size() == 0) begin
      report_error("result transfer with nothing outstanding");
      return;
    end
    want = pending_stats.pop_front();
    if (status_o !== want.st)
      report_error($sformatf("status %0d, want %0d", status_o, want.st));
    if (calls_o !== want.calls)
      report_error($sformatf("calls %0d, want %0d", calls_o, want.calls));
    if (trimmed_total_o !== want.trimmed)
      report_error($sformatf("trimmed_total %h, want %h", trimmed_total_o, want.trimmed));
    if (shortest_o !== want.shortest)
      report_error($sformatf("shortest %h, want %h", shortest_o, want.shortest));
    if (longest_o !== want.longest)
      report_error($sformatf("longest %h, want %h", longest_o, want.longest));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stuck_cycles, pending_stats.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
      @(negedge clk_i);
    end
  end

  // request side
  initial begin
    logic [TAG_W-1:0] tag_pool [POOL];
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  now_ts;
    tip_op_e          op;
    int               pick;
    int               reps;
    int               n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = '0;
    tag_i       = '0;
    timestamp_i = '0;
    slot_busy   = '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (n = 2; n < POOL; n++) tag_pool[n] = $urandom();
    now_ts = wide_rand();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (n = 0; n < N_PLAN; n++) send_event(plan[n]);

    // mostly begin/end pairs on a pool of tags larger than the table, so it fills up
    while (events_sent < TARGET_EVENTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) now_ts = wide_rand();
      if (pick < 80) begin
        tag  = tag_pool[$urandom_range(0, POOL - 1)];
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          now_ts += TS_W'($urandom_range(1, 200));
          send_event(ev(OP_BEGIN, tag, now_ts));
          if ($urandom_range(0, 24) == 0) now_ts += wide_rand();
          else now_ts += TS_W'($urandom_range(0, 5000));
          send_event(ev(OP_END, tag, now_ts));
        end
        if ($urandom_range(0, 9) < 7) send_event(ev(OP_READ, tag, wide_rand()));
      end else if (pick < 88) begin
        send_event(ev(OP_READ, tag_pool[$urandom_range(0, POOL - 1)], wide_rand()));
      end else if (pick < 90) begin
        send_event(ev(OP_CLEAR, $urandom(), wide_rand()));
      end else begin
        op  = tip_op_e'($urandom_range(0, 3));
        tag = $urandom();
        if (op == OP_BEGIN && !(&slot_busy)) tag = tag_pool[$urandom_range(0, POOL - 1)];
        send_event(ev(op, tag, wide_rand()));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d events sent, %0d results checked, %0d reads with full statistics",
             events_sent, results_seen, good_reads);
    $display("status mix: ok %0d, table full %0d, unknown tag %0d, too few calls %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
